// ----- rtl/core/polygon_centroid_shoelace_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the polygon centroid block
// Clocked property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef POLYGON_CENTROID_SHOELACE_TOP_ASSERT_SVH
`define POLYGON_CENTROID_SHOELACE_TOP_ASSERT_SVH

// Check on every rising edge of clk_i outside reset.
`define PCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every rising edge of clk_i, reset included.
`define PCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/pcs_pkg.sv -----
// ----------------------------------------------------------------------------
// pcs_pkg
// Widths, codes and handshake types shared by the centroid block modules.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int unsigned MaxVerticesDef = 256;
  localparam int unsigned MinVertices    = 3;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned SumW     = CoordW + 1;       // sum of two coordinates
  localparam int unsigned CrossW   = 2 * CoordW + 1;   // signed cross product
  localparam int unsigned MulBW    = CrossW + 1;       // signed multiplier operand
  localparam int unsigned ProdW    = SumW + 1 + MulBW; // signed multiplier result
  localparam int unsigned AreaW    = 42;
  localparam int unsigned MomW     = 58;
  localparam int unsigned DenW     = AreaW + 2;        // three times the area
  localparam int unsigned TAreaW   = 33;
  localparam int unsigned QuotW    = CoordW;
  localparam int unsigned InDataW  = 2 * CoordW;
  localparam int unsigned OutPackW = 2 * CoordW + TAreaW;
  localparam int unsigned OutDataW = ((OutPackW + 7) / 8) * 8;

  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_P0,
    TAG_P1,
    TAG_MX,
    TAG_MY
  } mul_tag_e;

  typedef struct packed {
    mul_tag_e              tag;
    logic [SumW-1:0]       a;
    logic [MulBW-1:0]      b;
  } mul_req_t;

  typedef struct packed {
    mul_tag_e              tag;
    logic [ProdW-1:0]      prod;
  } mul_rsp_t;

  typedef struct packed {
    logic                  start;
    logic [MomW-1:0]       num;
    logic [DenW-1:0]       den;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [QuotW-1:0]      quot;
  } div_rsp_t;

endpackage

// ----- rtl/core/polygon_centroid_shoelace_top.sv -----
// Each vertex runs a sequencer pass (accept, four multiplier issues, one wait for the
// cross product) before the next one is taken; a first vertex or one past the cap, if
// not also last, needs none. The result of the last vertex follows the remaining edges on
// the multiplier and two quotients on the divider; a clamped quotient ends early. A waiting
// output result holds back vertices only while the next one waits to emit. Reset (rst_ni
// low, asynchronous) clears the accumulators, the vertex count and the output valid at once.
// ----------------------------------------------------------------------------
// polygon_centroid_shoelace_top
// Shoelace centroid of a vertex stream: shared multiplier under a sequencer,
// closing edge on the last vertex, then a shared divider for both coordinates.
// ----------------------------------------------------------------------------
module polygon_centroid_shoelace_top
  import pcs_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // vertex_x, vertex_y
  input  logic                s_axis_tlast,   // last_vertex
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // centroid_x, centroid_y, twice_area, pad
  output logic                m_axis_tuser    // degenerate
);

`include "polygon_centroid_shoelace_top_assert.svh"

  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_M0,
    S_M1,
    S_WAIT,
    S_M2,
    S_M3,
    S_DRAIN,
    S_DIVX,
    S_WX,
    S_DIVY,
    S_WY,
    S_EMIT
  } state_e;

  state_e                  state_q, state_d;
  logic [CoordW-1:0]       first_x_q, first_x_d, first_y_q, first_y_d;
  logic [CoordW-1:0]       prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic signed [AreaW-1:0] area_q, area_d;
  logic signed [MomW-1:0]  momx_q, momx_d, momy_q, momy_d;
  logic [CoordW-1:0]       ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic [2*CoordW-1:0]     p0_q, p0_d;
  logic signed [CrossW-1:0] c_q, c_d;
  logic                    close_q, close_d, fin_q, fin_d;
  logic [DenW-1:0]         den_q, den_d;
  logic [TAreaW-1:0]       tarea_q, tarea_d;
  logic                    degen_q, degen_d;
  logic [QuotW-1:0]        qx_q, qx_d, qy_q, qy_d;
  logic                    ovalid_q, ovalid_d;
  logic [CoordW-1:0]       ocx_q, ocx_d, ocy_q, ocy_d;
  logic [TAreaW-1:0]       otarea_q, otarea_d;
  logic                    odegen_q, odegen_d;

  logic                    accept;
  logic [CoordW-1:0]       vx, vy;
  logic                    room, take_edge;
  logic signed [CrossW-1:0] cross_c;
  logic [AreaW-1:0]        area_abs;
  logic                    degen_c;
  logic [DenW-1:0]         area_ext;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign vx        = s_axis_tdata[CoordW-1:0];
  assign vy        = s_axis_tdata[2*CoordW-1:CoordW];
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign room      = cnt_q < CntW'(MAX_VERTICES);
  assign take_edge = room && (cnt_q != '0);

  assign cross_c  = $signed({1'b0, p0_q}) - $signed({1'b0, mul_rsp.prod[2*CoordW-1:0]});
  assign area_abs = area_q[AreaW-1] ? (~area_q + 1'b1) : area_q;
  assign degen_c  = (area_q == '0) || (cnt_q < CntW'(MinVertices));
  assign area_ext = DenW'(area_q);

  // Multiplier issue per sequencer step.
  always_comb begin
    mul_req.tag = TAG_NONE;
    mul_req.a   = '0;
    mul_req.b   = '0;
    case (state_q)
      S_M0: begin
        mul_req.tag = TAG_P0;
        mul_req.a   = SumW'(ax_q);
        mul_req.b   = MulBW'(by_q);
      end
      S_M1: begin
        mul_req.tag = TAG_P1;
        mul_req.a   = SumW'(bx_q);
        mul_req.b   = MulBW'(ay_q);
      end
      S_M2: begin
        mul_req.tag = TAG_MX;
        mul_req.a   = SumW'(ax_q) + SumW'(bx_q);
        mul_req.b   = {c_q[CrossW-1], c_q};
      end
      S_M3: begin
        mul_req.tag = TAG_MY;
        mul_req.a   = SumW'(ay_q) + SumW'(by_q);
        mul_req.b   = {c_q[CrossW-1], c_q};
      end
      default: begin
        mul_req.tag = TAG_NONE;
      end
    endcase
  end

  assign div_req.start = (state_q == S_DIVX) || (state_q == S_DIVY);
  assign div_req.num   = (state_q == S_DIVY) ? momy_q : momx_q;
  assign div_req.den   = den_q;

  pcs_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mul_req_i (mul_req),
    .mul_rsp_o (mul_rsp)
  );

  pcs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_req_i (div_req),
    .div_rsp_o (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    first_x_d = first_x_q;
    first_y_d = first_y_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    cnt_d     = cnt_q;
    area_d    = area_q;
    momx_d    = momx_q;
    momy_d    = momy_q;
    ax_d      = ax_q;
    ay_d      = ay_q;
    bx_d      = bx_q;
    by_d      = by_q;
    p0_d      = p0_q;
    c_d       = c_q;
    close_d   = close_q;
    fin_d     = fin_q;
    den_d     = den_q;
    tarea_d   = tarea_q;
    degen_d   = degen_q;
    qx_d      = qx_q;
    qy_d      = qy_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    ocx_d     = ocx_q;
    ocy_d     = ocy_q;
    otarea_d  = otarea_q;
    odegen_d  = odegen_q;

    // Fold multiplier results into the sums, keyed by their tag.
    case (mul_rsp.tag)
      TAG_P0: p0_d = mul_rsp.prod[2*CoordW-1:0];
      TAG_P1: begin
        c_d    = cross_c;
        area_d = area_q + AreaW'(cross_c);
      end
      TAG_MX: momx_d = momx_q + MomW'($signed(mul_rsp.prod));
      TAG_MY: momy_d = momy_q + MomW'($signed(mul_rsp.prod));
      default: ;
    endcase

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (room) begin
            if (cnt_q == '0) begin
              first_x_d = vx;
              first_y_d = vy;
            end
            prev_x_d = vx;
            prev_y_d = vy;
            cnt_d    = cnt_q + 1'b1;
          end
          if (take_edge) begin
            ax_d    = prev_x_q;
            ay_d    = prev_y_q;
            bx_d    = vx;
            by_d    = vy;
            close_d = s_axis_tlast;
            fin_d   = 1'b0;
            state_d = S_M0;
          end else if (s_axis_tlast) begin
            // closing edge only: new previous vertex back to the first
            ax_d    = room ? vx : prev_x_q;
            ay_d    = room ? vy : prev_y_q;
            bx_d    = (cnt_q == '0) ? vx : first_x_q;
            by_d    = (cnt_q == '0) ? vy : first_y_q;
            close_d = 1'b0;
            fin_d   = 1'b1;
            state_d = S_M0;
          end
        end
      end
      S_M0:   state_d = S_M1;
      S_M1:   state_d = S_WAIT;
      S_WAIT: state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3: begin
        if (close_q) begin
          ax_d    = prev_x_q;
          ay_d    = prev_y_q;
          bx_d    = first_x_q;
          by_d    = first_y_q;
          close_d = 1'b0;
          fin_d   = 1'b1;
          state_d = S_M0;
        end else if (fin_q) begin
          state_d = S_DRAIN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DRAIN: begin
        den_d   = area_ext + (area_ext << 1);
        degen_d = degen_c;
        tarea_d = (area_abs > AreaW'({TAreaW{1'b1}})) ? '1 : area_abs[TAreaW-1:0];
        qx_d    = '0;
        qy_d    = '0;
        fin_d   = 1'b0;
        state_d = degen_c ? S_EMIT : S_DIVX;
      end
      S_DIVX: state_d = S_WX;
      S_WX: begin
        if (div_rsp.done) begin
          qx_d    = div_rsp.quot;
          state_d = S_DIVY;
        end
      end
      S_DIVY: state_d = S_WY;
      S_WY: begin
        if (div_rsp.done) begin
          qy_d    = div_rsp.quot;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free, then clear for the next polygon
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d  = 1'b1;
          ocx_d     = qx_q;
          ocy_d     = qy_q;
          otarea_d  = tarea_q;
          odegen_d  = degen_q;
          first_x_d = '0;
          first_y_d = '0;
          prev_x_d  = '0;
          prev_y_d  = '0;
          cnt_d     = '0;
          area_d    = '0;
          momx_d    = '0;
          momy_d    = '0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      cnt_q     <= '0;
      area_q    <= '0;
      momx_q    <= '0;
      momy_q    <= '0;
      ax_q      <= '0;
      ay_q      <= '0;
      bx_q      <= '0;
      by_q      <= '0;
      p0_q      <= '0;
      c_q       <= '0;
      close_q   <= 1'b0;
      fin_q     <= 1'b0;
      den_q     <= '0;
      tarea_q   <= '0;
      degen_q   <= 1'b0;
      qx_q      <= '0;
      qy_q      <= '0;
      ovalid_q  <= 1'b0;
      ocx_q     <= '0;
      ocy_q     <= '0;
      otarea_q  <= '0;
      odegen_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      first_x_q <= first_x_d;
      first_y_q <= first_y_d;
      prev_x_q  <= prev_x_d;
      prev_y_q  <= prev_y_d;
      cnt_q     <= cnt_d;
      area_q    <= area_d;
      momx_q    <= momx_d;
      momy_q    <= momy_d;
      ax_q      <= ax_d;
      ay_q      <= ay_d;
      bx_q      <= bx_d;
      by_q      <= by_d;
      p0_q      <= p0_d;
      c_q       <= c_d;
      close_q   <= close_d;
      fin_q     <= fin_d;
      den_q     <= den_d;
      tarea_q   <= tarea_d;
      degen_q   <= degen_d;
      qx_q      <= qx_d;
      qy_q      <= qy_d;
      ovalid_q  <= ovalid_d;
      ocx_q     <= ocx_d;
      ocy_q     <= ocy_d;
      otarea_q  <= otarea_d;
      odegen_q  <= odegen_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(OutDataW-OutPackW){1'b0}}, otarea_q, ocy_q, ocx_q};
  assign m_axis_tuser  = odegen_q;

  `PCS_ASSERT_ALWAYS(a_cnt_max, cnt_q <= CntW'(MAX_VERTICES), "vertex count past limit")
  `PCS_ASSERT(a_wait_p1, (state_q == S_WAIT) |-> (mul_rsp.tag == TAG_P1),
              "second cross product not back in time")
  `PCS_ASSERT(a_div_done, div_rsp.done |-> (state_q == S_WX || state_q == S_WY),
              "divider finished outside a wait step")
  `PCS_ASSERT(a_degen_zero, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[31:0] == '0),
              "degenerate result with nonzero centroid")

endmodule

// ----- rtl/core/pcs_mul.sv -----
// ----------------------------------------------------------------------------
// pcs_mul
// Shared registered multiplier; the request tag travels with the product.
// ----------------------------------------------------------------------------
module pcs_mul
  import pcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t mul_req_i,
  output mul_rsp_t mul_rsp_o
);

  logic signed [ProdW-1:0] prod_d;
  mul_rsp_t                rsp_q;

  // Operand a is unsigned, operand b is two's complement.
  assign prod_d = $signed({1'b0, mul_req_i.a}) * $signed(mul_req_i.b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_q.tag  <= TAG_NONE;
      rsp_q.prod <= '0;
    end else begin
      rsp_q.tag  <= mul_req_i.tag;
      rsp_q.prod <= prod_d;
    end
  end

  assign mul_rsp_o = rsp_q;

endmodule

// ----- rtl/core/pcs_div.sv -----
// ----------------------------------------------------------------------------
// pcs_div
// Iterative restoring divider, one quotient bit per cycle, with the quotient
// truncated toward zero and clamped to 0..2^QuotW-1.
// ----------------------------------------------------------------------------
module pcs_div
  import pcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t div_req_i,
  output div_rsp_t div_rsp_o
);

  localparam int unsigned DshW  = DenW + QuotW;
  localparam int unsigned StepW = $clog2(QuotW + 1);

  logic [MomW-1:0]  num_abs;
  logic [DenW-1:0]  den_abs;
  logic             ge;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             neg_q, neg_d;
  logic             sat_q, sat_d;
  logic [StepW-1:0] step_q, step_d;
  logic [MomW-1:0]  rem_q, rem_d;
  logic [DshW-1:0]  dsh_q, dsh_d;
  logic [QuotW-1:0] quot_q, quot_d;

  assign num_abs = div_req_i.num[MomW-1] ? (~div_req_i.num + 1'b1) : div_req_i.num;
  assign den_abs = div_req_i.den[DenW-1] ? (~div_req_i.den + 1'b1) : div_req_i.den;
  assign ge      = {{(DshW-MomW){1'b0}}, rem_q} >= dsh_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    sat_d  = sat_q;
    step_d = step_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (div_req_i.start) begin
      busy_d = 1'b1;
      neg_d  = div_req_i.num[MomW-1] ^ div_req_i.den[DenW-1];
      sat_d  = 1'b0;
      step_d = StepW'(QuotW);
      rem_d  = num_abs;
      dsh_d  = {den_abs, {QuotW{1'b0}}};
      quot_d = '0;
    end else if (busy_q) begin
      dsh_d = dsh_q >> 1;
      if (step_q == StepW'(QuotW)) begin
        // quotient of at least 2^QuotW: clamp and stop
        if (ge) begin
          sat_d  = 1'b1;
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          step_d = step_q - 1'b1;
        end
      end else begin
        if (ge) begin
          rem_d  = rem_q - dsh_q[MomW-1:0];
          quot_d = quot_q | (QuotW'(1) << step_q[StepW-2:0]);
        end
        if (step_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      sat_q  <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dsh_q  <= '0;
      quot_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      neg_q  <= neg_d;
      sat_q  <= sat_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      dsh_q  <= dsh_d;
      quot_q <= quot_d;
    end
  end

  // Opposite signs give a quotient of zero or below, which clamps to zero.
  assign div_rsp_o.done = done_q;
  assign div_rsp_o.quot = neg_q ? '0 : (sat_q ? '1 : quot_q);

endmodule
